### hdl/bdq_pkg.sv
// Shared types and codes for the bounded deque core.
// No dependencies.
package bdq_pkg;

   localparam int BDQ_CAPACITY = 64;
   localparam int WORD_W       = 32;

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_DELETE     = 3'd4,
      REQ_CLEAR      = 3'd5
   } req_type_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOADF,
      ST_LOADB,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } state_type;

endpackage

### hdl/bdq_ram.sv
// Element store: one write port, one read port, registered read data.
// Depends on bdq_pkg.
module bdq_ram #(
   parameter int DEPTH = bdq_pkg::BDQ_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bdq_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [bdq_pkg::WORD_W-1:0] rd_data
);
   import bdq_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bounded_deque_with_delete_core.sv
// Bounded deque core: control sequencer over the element store.
// Depends on bdq_pkg and bdq_ram.
//
// One transaction at a time. Push, clear and rejected requests pass through the
// execute and respond states; pops and front/back deletes that leave words behind
// add one store read to refresh the cached end word. An interior delete walks the
// store through its single read port: a read and a compare per element scanned up to
// the match, then a read and a write per element moved up behind it. A new request
// is taken while the previous result still waits in the output register.
module bounded_deque_with_delete_core #(
   parameter int CAPACITY = bdq_pkg::BDQ_CAPACITY,
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int RW       = ((2 + CW + 2 * bdq_pkg::WORD_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bdq_pkg::WORD_W-1:0] req_tdata,  // value
   input  logic [2:0]                 req_tuser,  // req_type
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RW-1:0]              rsp_tdata   // status, count, front_value, back_value
);
   import bdq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SW = CW + 1;

   state_type         state_ff, state_in;
   req_type_type      req_ff, req_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [WORD_W-1:0] fval_ff, fval_in;
   logic [WORD_W-1:0] bval_ff, bval_in;
   status_type        status_ff, status_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]     rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              full, empty, accept, rsp_free;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   bdq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            case (req_ff)
               REQ_POP_FRONT: begin
                  if (count_ff > CW'(1)) state_in = ST_LOADF;
               end
               REQ_POP_BACK: begin
                  if (count_ff > CW'(1)) state_in = ST_LOADB;
               end
               REQ_DELETE: begin
                  if (empty) state_in = ST_RESP;
                  else if (fval_ff == value_ff) begin
                     if (count_ff > CW'(1)) state_in = ST_LOADF;
                  end else if (bval_ff == value_ff) begin
                     if (count_ff > CW'(1)) state_in = ST_LOADB;
                  end else if (count_ff > CW'(2)) state_in = ST_SCAN_RD;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_LOADF:    state_in = ST_RESP;
         ST_LOADB:    state_in = ST_RESP;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (rd_data == value_ff) state_in = ST_SHIFT_RD;
            else if (idx_ff + CW'(2) >= count_ff) state_in = ST_RESP;
            else state_in = ST_SCAN_RD;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (idx_ff + CW'(2) < count_ff) state_in = ST_SHIFT_RD;
            else state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      req_in       = req_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      fval_in      = fval_ff;
      bval_in      = bval_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = wrap(front_ff, idx_ff);
      wr_data      = rd_data;
      rd_addr      = wrap(front_ff, idx_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_type_type'(req_tuser);
               value_in = req_tdata;
            end
         end
         ST_EXEC: begin
            status_in = STAT_DONE;
            case (req_ff)
               REQ_PUSH_FRONT: begin
                  if (full) status_in = STAT_FULL;
                  else begin
                     front_in = (front_ff == '0) ? AW'(CAPACITY - 1) : front_ff - AW'(1);
                     wr_en    = 1'b1;
                     wr_addr  = front_in;
                     wr_data  = value_ff;
                     count_in = count_ff + CW'(1);
                     fval_in  = value_ff;
                     if (empty) bval_in = value_ff;
                  end
               end
               REQ_PUSH_BACK: begin
                  if (full) status_in = STAT_FULL;
                  else begin
                     wr_en    = 1'b1;
                     wr_addr  = wrap(front_ff, count_ff);
                     wr_data  = value_ff;
                     count_in = count_ff + CW'(1);
                     bval_in  = value_ff;
                     if (empty) fval_in = value_ff;
                  end
               end
               REQ_POP_FRONT, REQ_POP_BACK, REQ_DELETE: begin
                  if (empty) status_in = STAT_EMPTY;
                  else if ((req_ff == REQ_POP_FRONT) ||
                           ((req_ff == REQ_DELETE) && (fval_ff == value_ff))) begin
                     front_in = wrap(front_ff, CW'(1));
                     count_in = count_ff - CW'(1);
                     rd_addr  = wrap(front_ff, CW'(1));
                     if (count_ff == CW'(1)) begin
                        fval_in = '0;
                        bval_in = '0;
                     end
                  end else if ((req_ff == REQ_POP_BACK) || (bval_ff == value_ff)) begin
                     count_in = count_ff - CW'(1);
                     rd_addr  = wrap(front_ff, count_ff - CW'(2));
                     if (count_ff == CW'(1)) begin
                        fval_in = '0;
                        bval_in = '0;
                     end
                  end else if (count_ff > CW'(2)) begin
                     idx_in = CW'(1);
                  end else begin
                     status_in = STAT_NOTFOUND;
                  end
               end
               REQ_CLEAR: begin
                  count_in = '0;
                  front_in = '0;
                  fval_in  = '0;
                  bval_in  = '0;
               end
               default: status_in = STAT_DONE;
            endcase
         end
         ST_LOADF: fval_in = rd_data;
         ST_LOADB: bval_in = rd_data;
         ST_SCAN_RD: rd_addr = wrap(front_ff, idx_ff);
         ST_SCAN_CMP: begin
            if (rd_data != value_ff) begin
               if (idx_ff + CW'(2) >= count_ff) status_in = STAT_NOTFOUND;
               else idx_in = idx_ff + CW'(1);
            end
         end
         ST_SHIFT_RD: rd_addr = wrap(front_ff, idx_ff + CW'(1));
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = wrap(front_ff, idx_ff);
            wr_data = rd_data;
            if (idx_ff + CW'(2) < count_ff) idx_in = idx_ff + CW'(1);
            else count_in = count_ff - CW'(1);
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RW'({bval_ff, fval_ff, count_ff, status_ff});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         fval_ff      <= '0;
         bval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         fval_ff      <= fval_in;
         bval_ff      <= bval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   a_empty_ends_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff == '0) |-> (fval_ff == '0 && bval_ff == '0))
      else $error("empty queue with nonzero end words");

   a_front_range: assert property (@(posedge clock) disable iff (reset)
      SW'(front_ff) < SW'(CAPACITY))
      else $error("front position out of range");

endmodule
